// ----- rtl/oli_pkg.sv -----
// Package for the ordered list block: operation and status codes, the
// control struct broadcast to the cells, and the default depth.
// Depends on nothing; used by oli_cell and ordered_list_insert_delete.
package oli_pkg;

  // Default number of cells in the list.
  localparam int unsigned DefaultDepth = 16;

  // Field widths fixed by the item format.
  localparam int unsigned ValueW    = 32;
  localparam int unsigned PositionW = 4;
  localparam int unsigned CountW    = 5;

  // Operation carried by an input item.
  typedef enum logic [1:0] {
    MODE_INSERT_FRONT = 2'd0,
    MODE_DELETE_FRONT = 2'd1,
    MODE_DELETE_END   = 2'd2,
    MODE_DELETE_AT    = 2'd3
  } oli_mode_e;

  // Status reported with every result item.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_OOB   = 2'd2,
    STATUS_FULL  = 2'd3
  } oli_status_e;

  // Shift command broadcast to every cell in a cycle.
  typedef struct packed {
    logic ins;  // every cell takes its front neighbor's data
    logic del;  // cells at or behind the target take the back neighbor's data
  } oli_ctrl_t;

endpackage

// ----- rtl/oli_cell.sv -----
// One cell of the list: holds a single entry and moves it to or from its
// neighbors on insert and delete. Depends on oli_pkg.
module oli_cell #(
  parameter int unsigned Idx = 0,
  parameter int unsigned IdxW = 4
) (
  input  logic                       clk_i,
  input  oli_pkg::oli_ctrl_t         ctrl_i,
  input  logic [IdxW-1:0]            pos_i,
  input  logic [oli_pkg::ValueW-1:0] front_i,
  input  logic [oli_pkg::ValueW-1:0] back_i,
  output logic [oli_pkg::ValueW-1:0] data_o,
  output logic [oli_pkg::ValueW-1:0] taken_o
);
  import oli_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic [ValueW-1:0] data_q, data_d;
  logic              at_or_behind;
  logic              is_target;

  assign at_or_behind = (MyIdx >= pos_i);
  assign is_target    = (MyIdx == pos_i);

  // Next entry: shift back on insert, close the gap on delete.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      data_d = front_i;
    end else if (ctrl_i.del && at_or_behind) begin
      data_d = back_i;
    end
  end

  // Entry storage; payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Offer this cell's entry when it is the one addressed.
  assign data_o  = data_q;
  assign taken_o = is_target ? data_q : '0;

endmodule

// ----- rtl/ordered_list_insert_delete.sv -----
// Top level of the ordered list: a row of oli_cell entries, the count and
// the result register. Depends on oli_pkg and oli_cell.
//
//  Channel  Dir  tdata (low bit up)                   tuser
//  s_axis   in   value[31:0], position[35:32], pad    mode[1:0]
//  m_axis   out  removed_value[31:0], entry_count[36:32], pad  status[1:0]
//
// Every item is finished where it is accepted: all cells shift together in the cycle
// the item is accepted and the result is registered at that edge.
// Throughput is one item per cycle unless the result stalls; the path is
// the target-position compare plus the cell OR that picks the removed entry.
// Reset empties the list at once; no clearing pass is needed.
// A new item is taken while the held result leaves in the same cycle;
// a stalled result stalls the input.
module ordered_list_insert_delete #(
  parameter int unsigned DEPTH = oli_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value[31:0], position[35:32], zero pad
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // removed_value[31:0], entry_count[36:32], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import oli_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > PositionW) ? CntW : PositionW;
  localparam int unsigned ExtW = (CntW > CountW) ? CntW : CountW;
  localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);

  // Input fields.
  oli_mode_e            mode;
  logic [ValueW-1:0]    value;
  logic [PositionW-1:0] position;

  assign mode     = oli_mode_e'(s_axis_tuser);
  assign value    = s_axis_tdata[ValueW-1:0];
  assign position = s_axis_tdata[ValueW +: PositionW];

  // Control and result registers.
  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q;
  logic [ValueW-1:0] removed_q;
  logic [CountW-1:0] out_count_q;
  oli_status_e       status_q;

  logic              accept;
  logic              is_empty, is_full, oob;
  logic [CmpW-1:0]   target;
  oli_status_e       status_d;
  oli_ctrl_t         ctrl;
  logic [ValueW-1:0] removed_d;
  logic [ExtW-1:0]   count_ext;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_empty      = (count_q == '0);
  assign is_full       = (count_q >= FullCount);

  // Pick the position an operation removes from.
  always_comb begin
    unique case (mode)
      MODE_DELETE_FRONT: target = '0;
      MODE_DELETE_END:   target = CmpW'(count_q - 1'b1);
      MODE_DELETE_AT:    target = CmpW'(position);
      default:           target = '0;
    endcase
  end

  assign oob = (target >= CmpW'(count_q));

  // Decide the outcome of the item.
  always_comb begin
    status_d = STATUS_OK;
    ctrl     = '0;
    if (mode == MODE_INSERT_FRONT) begin
      if (is_full) begin
        status_d = STATUS_FULL;
      end else begin
        ctrl.ins = accept;
      end
    end else if (is_empty) begin
      status_d = STATUS_EMPTY;
    end else if (oob) begin
      status_d = STATUS_OOB;
    end else begin
      ctrl.del = accept;
    end
  end

  // Row of cells; cell 0 is the front.
  logic [ValueW-1:0] cell_data  [DEPTH];
  logic [ValueW-1:0] cell_taken [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ValueW-1:0] front, back;
    if (k == 0) begin : g_front
      assign front = value;
    end else begin : g_mid_front
      assign front = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_back
      assign back = '0;
    end else begin : g_mid_back
      assign back = cell_data[k+1];
    end

    oli_cell #(
      .Idx  (k),
      .IdxW (IdxW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (target[IdxW-1:0]),
      .front_i (front),
      .back_i  (back),
      .data_o  (cell_data[k]),
      .taken_o (cell_taken[k])
    );
  end

  // Gather the removed entry; only the addressed cell is nonzero.
  always_comb begin
    removed_d = '0;
    for (int k = 0; k < DEPTH; k++) begin
      removed_d = removed_d | cell_taken[k];
    end
    if (!ctrl.del) begin
      removed_d = '0;
    end
  end

  // Count after the operation.
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.del) begin
      count_d = count_q - 1'b1;
    end
  end

  assign count_ext = ExtW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q   <= removed_d;
      out_count_q <= count_ext[CountW-1:0];
      status_q    <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_count_q, removed_q};
  assign m_axis_tuser  = status_q;

  // Checks on the count and the result register.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count exceeds depth");

  a_insert_delete_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins && ctrl.del))
    else $error("insert and delete in the same cycle");

  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item produced no result");

  a_fail_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_d != STATUS_OK) |=> count_q == $past(count_q))
    else $error("failed operation changed the count");

  a_fail_removes_nothing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != STATUS_OK) |-> removed_q == '0)
    else $error("failed operation reports a removed entry");

endmodule
